/* src/cfa_pkg.sv */
package cfa_pkg;

    localparam int CFA_DATA_WIDTH = 16;
    localparam int OP_WIDTH = 5;

    localparam logic [OP_WIDTH-1:0] OP_ADD    = 5'd0;
    localparam logic [OP_WIDTH-1:0] OP_SUB    = 5'd1;
    localparam logic [OP_WIDTH-1:0] OP_MUL    = 5'd2;
    localparam logic [OP_WIDTH-1:0] OP_DIV    = 5'd3;
    localparam logic [OP_WIDTH-1:0] OP_MOD    = 5'd4;
    localparam logic [OP_WIDTH-1:0] OP_AND    = 5'd5;
    localparam logic [OP_WIDTH-1:0] OP_OR     = 5'd6;
    localparam logic [OP_WIDTH-1:0] OP_XOR    = 5'd7;
    localparam logic [OP_WIDTH-1:0] OP_NEG    = 5'd8;
    localparam logic [OP_WIDTH-1:0] OP_COMPL  = 5'd9;
    localparam logic [OP_WIDTH-1:0] OP_SHL    = 5'd10;
    localparam logic [OP_WIDTH-1:0] OP_SHR    = 5'd11;
    localparam logic [OP_WIDTH-1:0] OP_EQ     = 5'd12;
    localparam logic [OP_WIDTH-1:0] OP_NE     = 5'd13;
    localparam logic [OP_WIDTH-1:0] OP_LT     = 5'd14;
    localparam logic [OP_WIDTH-1:0] OP_GT     = 5'd15;
    localparam logic [OP_WIDTH-1:0] OP_LE     = 5'd16;
    localparam logic [OP_WIDTH-1:0] OP_GE     = 5'd17;
    localparam logic [OP_WIDTH-1:0] OP_SELECT = 5'd18;

    typedef struct packed {
        logic fold;
        logic div_err;
        logic sel_mul;
        logic sel_div;
        logic sel_mod;
        logic neg_quo;
        logic neg_rem;
    } cfa_ctl_t;

endpackage

/* src/cfa_front.sv */
module cfa_front import cfa_pkg::*; #(
    parameter int DATA_WIDTH = CFA_DATA_WIDTH
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         en,
    input  logic                         in_valid,
    input  logic [OP_WIDTH-1:0]          op,
    input  logic signed [DATA_WIDTH-1:0] left_value,
    input  logic                         left_is_const,
    input  logic                         left_unsigned,
    input  logic signed [DATA_WIDTH-1:0] right_value,
    input  logic                         right_is_const,
    input  logic                         right_unsigned,
    input  logic signed [DATA_WIDTH-1:0] false_value,
    input  logic                         false_is_const,
    output logic                         out_valid,
    output cfa_ctl_t                     out_ctl,
    output logic [DATA_WIDTH-1:0]        out_res,
    output logic [DATA_WIDTH-1:0]        out_a,
    output logic [DATA_WIDTH-1:0]        out_b,
    output logic [DATA_WIDTH-1:0]        out_ma,
    output logic [DATA_WIDTH-1:0]        out_mb
);

    logic                  valid_reg;
    cfa_ctl_t              ctl_reg, ctl_next;
    logic [DATA_WIDTH-1:0] res_reg, res_next;
    logic [DATA_WIDTH-1:0] a_reg, b_reg;
    logic [DATA_WIDTH-1:0] ma_reg, ma_next;
    logic [DATA_WIDTH-1:0] mb_reg, mb_next;
    logic [DATA_WIDTH-1:0] a, b, f;
    logic                  uns, both, cmp;

    always_comb begin
        a    = left_value;
        b    = right_value;
        f    = false_value;
        uns  = left_unsigned | right_unsigned;
        both = left_is_const & right_is_const;
        cmp  = 1'b0;
        ctl_next = '0;
        res_next = '0;
        ma_next = (!uns && a[DATA_WIDTH-1]) ? (~a + 1'b1) : a;
        mb_next = (!uns && b[DATA_WIDTH-1]) ? (~b + 1'b1) : b;
        case (op)
            OP_ADD: begin
                ctl_next.fold = both;
                res_next = a + b;
            end
            OP_SUB: begin
                ctl_next.fold = both;
                res_next = a - b;
            end
            OP_MUL: begin
                ctl_next.fold = both;
                ctl_next.sel_mul = both;
            end
            OP_DIV, OP_MOD: begin
                if (both) begin
                    if (b == '0) begin
                        ctl_next.div_err = 1'b1;
                    end else begin
                        ctl_next.fold    = 1'b1;
                        ctl_next.sel_div = (op == OP_DIV);
                        ctl_next.sel_mod = (op == OP_MOD);
                        ctl_next.neg_quo = !uns && (a[DATA_WIDTH-1] ^ b[DATA_WIDTH-1]);
                        ctl_next.neg_rem = !uns && a[DATA_WIDTH-1];
                    end
                end
            end
            OP_AND: begin
                ctl_next.fold = both;
                res_next = a & b;
            end
            OP_OR: begin
                ctl_next.fold = both;
                res_next = a | b;
            end
            OP_XOR: begin
                ctl_next.fold = both;
                res_next = a ^ b;
            end
            OP_NEG: begin
                ctl_next.fold = left_is_const;
                res_next = ~a + 1'b1;
            end
            OP_COMPL: begin
                ctl_next.fold = left_is_const;
                res_next = ~a;
            end
            OP_SHL: begin
                ctl_next.fold = both;
                res_next = a << b;
            end
            OP_SHR: begin
                ctl_next.fold = both;
                res_next = uns ? (a >> b) : DATA_WIDTH'($signed(a) >>> b);
            end
            OP_EQ, OP_NE, OP_LT, OP_GT, OP_LE, OP_GE: begin
                ctl_next.fold = both;
                case (op)
                    OP_EQ:   cmp = (a == b);
                    OP_NE:   cmp = (a != b);
                    OP_LT:   cmp = ($signed(a) < $signed(b));
                    OP_GT:   cmp = ($signed(a) > $signed(b));
                    OP_LE:   cmp = ($signed(a) <= $signed(b));
                    default: cmp = ($signed(a) >= $signed(b));
                endcase
                res_next = {{(DATA_WIDTH-1){1'b0}}, cmp};
            end
            OP_SELECT: begin
                ctl_next.fold = both & false_is_const;
                res_next = (a != '0) ? b : f;
            end
            default: begin
                ctl_next = '0;
            end
        endcase
        if (!ctl_next.fold) begin
            res_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ctl_reg <= ctl_next;
            res_reg <= res_next;
            a_reg   <= a;
            b_reg   <= b;
            ma_reg  <= ma_next;
            mb_reg  <= mb_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_ctl   = ctl_reg;
    assign out_res   = res_reg;
    assign out_a     = a_reg;
    assign out_b     = b_reg;
    assign out_ma    = ma_reg;
    assign out_mb    = mb_reg;

endmodule

/* src/cfa_cell.sv */
module cfa_cell import cfa_pkg::*; #(
    parameter int DATA_WIDTH = CFA_DATA_WIDTH
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  en,
    input  logic                  in_valid,
    input  cfa_ctl_t              in_ctl,
    input  logic [DATA_WIDTH-1:0] in_res,
    input  logic [DATA_WIDTH-1:0] in_rem,
    input  logic [DATA_WIDTH-1:0] in_dq,
    input  logic [DATA_WIDTH-1:0] in_mb,
    input  logic [DATA_WIDTH-1:0] in_prod,
    input  logic [DATA_WIDTH-1:0] in_ash,
    input  logic [DATA_WIDTH-1:0] in_bsh,
    output logic                  out_valid,
    output cfa_ctl_t              out_ctl,
    output logic [DATA_WIDTH-1:0] out_res,
    output logic [DATA_WIDTH-1:0] out_rem,
    output logic [DATA_WIDTH-1:0] out_dq,
    output logic [DATA_WIDTH-1:0] out_mb,
    output logic [DATA_WIDTH-1:0] out_prod,
    output logic [DATA_WIDTH-1:0] out_ash,
    output logic [DATA_WIDTH-1:0] out_bsh
);

    logic                  valid_reg;
    cfa_ctl_t              ctl_reg;
    logic [DATA_WIDTH-1:0] res_reg, mb_reg;
    logic [DATA_WIDTH-1:0] rem_reg, rem_next;
    logic [DATA_WIDTH-1:0] dq_reg, dq_next;
    logic [DATA_WIDTH-1:0] prod_reg, prod_next;
    logic [DATA_WIDTH-1:0] ash_reg, bsh_reg;
    logic [DATA_WIDTH:0]   trial;

    // One restoring division step and one shift-and-add multiply step.
    always_comb begin
        trial = {in_rem, in_dq[DATA_WIDTH-1]} - {1'b0, in_mb};
        if (!trial[DATA_WIDTH]) begin
            rem_next = trial[DATA_WIDTH-1:0];
            dq_next  = {in_dq[DATA_WIDTH-2:0], 1'b1};
        end else begin
            rem_next = {in_rem[DATA_WIDTH-2:0], in_dq[DATA_WIDTH-1]};
            dq_next  = {in_dq[DATA_WIDTH-2:0], 1'b0};
        end
        prod_next = in_bsh[0] ? (in_prod + in_ash) : in_prod;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ctl_reg  <= in_ctl;
            res_reg  <= in_res;
            mb_reg   <= in_mb;
            rem_reg  <= rem_next;
            dq_reg   <= dq_next;
            prod_reg <= prod_next;
            ash_reg  <= {in_ash[DATA_WIDTH-2:0], 1'b0};
            bsh_reg  <= {1'b0, in_bsh[DATA_WIDTH-1:1]};
        end
    end

    assign out_valid = valid_reg;
    assign out_ctl   = ctl_reg;
    assign out_res   = res_reg;
    assign out_rem   = rem_reg;
    assign out_dq    = dq_reg;
    assign out_mb    = mb_reg;
    assign out_prod  = prod_reg;
    assign out_ash   = ash_reg;
    assign out_bsh   = bsh_reg;

endmodule

/* src/cfa_tail.sv */
module cfa_tail import cfa_pkg::*; #(
    parameter int DATA_WIDTH = CFA_DATA_WIDTH
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         in_valid,
    input  cfa_ctl_t                     in_ctl,
    input  logic [DATA_WIDTH-1:0]        in_res,
    input  logic [DATA_WIDTH-1:0]        in_rem,
    input  logic [DATA_WIDTH-1:0]        in_dq,
    input  logic [DATA_WIDTH-1:0]        in_prod,
    output logic                         pipe_en,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic                         m_folded,
    output logic signed [DATA_WIDTH-1:0] m_result_value,
    output logic                         m_divide_error
);

    logic                  out_valid_reg, skid_valid_reg;
    logic                  out_fold_reg, out_err_reg;
    logic [DATA_WIDTH-1:0] out_val_reg;
    logic                  skid_fold_reg, skid_err_reg;
    logic [DATA_WIDTH-1:0] skid_val_reg;
    logic [DATA_WIDTH-1:0] value_next, quo, rem;
    logic                  incoming;

    always_comb begin
        quo = in_ctl.neg_quo ? (~in_dq + 1'b1) : in_dq;
        rem = in_ctl.neg_rem ? (~in_rem + 1'b1) : in_rem;
        if (in_ctl.sel_mul) begin
            value_next = in_prod;
        end else if (in_ctl.sel_div) begin
            value_next = quo;
        end else if (in_ctl.sel_mod) begin
            value_next = rem;
        end else begin
            value_next = in_res;
        end
    end

    assign pipe_en  = !skid_valid_reg;
    assign incoming = in_valid && pipe_en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (m_ready || !out_valid_reg) begin
            out_valid_reg  <= skid_valid_reg || incoming;
            skid_valid_reg <= 1'b0;
        end else if (incoming) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (m_ready || !out_valid_reg) begin
            if (skid_valid_reg) begin
                out_fold_reg <= skid_fold_reg;
                out_err_reg  <= skid_err_reg;
                out_val_reg  <= skid_val_reg;
            end else begin
                out_fold_reg <= in_ctl.fold;
                out_err_reg  <= in_ctl.div_err;
                out_val_reg  <= value_next;
            end
        end else if (incoming) begin
            skid_fold_reg <= in_ctl.fold;
            skid_err_reg  <= in_ctl.div_err;
            skid_val_reg  <= value_next;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_folded       = out_fold_reg;
    assign m_divide_error = out_err_reg;
    assign m_result_value = out_val_reg;

endmodule

/* src/constant_fold_alu.sv */
// Constant folder for a DATA_WIDTH-bit integer ALU. Each input word carries an
// operator code and up to three operands with their constant flags; each output
// word tells whether the expression folded, the wrapped result, and whether a
// division or modulo by zero was attempted. A new word is taken every cycle
// while ready is high, and results leave in order after passing one decode
// stage, a row of DATA_WIDTH cells that each produce one quotient bit and one
// multiplier partial sum, and an output register backed by a one-word skid
// buffer. The input side drops ready only while that skid buffer is full.
module constant_fold_alu import cfa_pkg::*; #(
    parameter int DATA_WIDTH = CFA_DATA_WIDTH
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [OP_WIDTH-1:0]          s_op,
    input  logic signed [DATA_WIDTH-1:0] s_left_value,
    input  logic                         s_left_is_const,
    input  logic                         s_left_unsigned,
    input  logic signed [DATA_WIDTH-1:0] s_right_value,
    input  logic                         s_right_is_const,
    input  logic                         s_right_unsigned,
    input  logic signed [DATA_WIDTH-1:0] s_false_value,
    input  logic                         s_false_is_const,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic                         m_folded,
    output logic signed [DATA_WIDTH-1:0] m_result_value,
    output logic                         m_divide_error
);

    logic                  pipe_en;
    logic                  valid_w [0:DATA_WIDTH];
    cfa_ctl_t              ctl_w   [0:DATA_WIDTH];
    logic [DATA_WIDTH-1:0] res_w   [0:DATA_WIDTH];
    logic [DATA_WIDTH-1:0] rem_w   [0:DATA_WIDTH];
    logic [DATA_WIDTH-1:0] dq_w    [0:DATA_WIDTH];
    logic [DATA_WIDTH-1:0] mb_w    [0:DATA_WIDTH];
    logic [DATA_WIDTH-1:0] prod_w  [0:DATA_WIDTH];
    logic [DATA_WIDTH-1:0] ash_w   [0:DATA_WIDTH];
    logic [DATA_WIDTH-1:0] bsh_w   [0:DATA_WIDTH];

    assign s_ready = pipe_en;

    cfa_front #(.DATA_WIDTH(DATA_WIDTH)) u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .en             (pipe_en),
        .in_valid       (s_valid),
        .op             (s_op),
        .left_value     (s_left_value),
        .left_is_const  (s_left_is_const),
        .left_unsigned  (s_left_unsigned),
        .right_value    (s_right_value),
        .right_is_const (s_right_is_const),
        .right_unsigned (s_right_unsigned),
        .false_value    (s_false_value),
        .false_is_const (s_false_is_const),
        .out_valid      (valid_w[0]),
        .out_ctl        (ctl_w[0]),
        .out_res        (res_w[0]),
        .out_a          (ash_w[0]),
        .out_b          (bsh_w[0]),
        .out_ma         (dq_w[0]),
        .out_mb         (mb_w[0])
    );

    assign rem_w[0]  = '0;
    assign prod_w[0] = '0;

    for (genvar i = 0; i < DATA_WIDTH; i++) begin : g_cell
        cfa_cell #(.DATA_WIDTH(DATA_WIDTH)) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (pipe_en),
            .in_valid  (valid_w[i]),
            .in_ctl    (ctl_w[i]),
            .in_res    (res_w[i]),
            .in_rem    (rem_w[i]),
            .in_dq     (dq_w[i]),
            .in_mb     (mb_w[i]),
            .in_prod   (prod_w[i]),
            .in_ash    (ash_w[i]),
            .in_bsh    (bsh_w[i]),
            .out_valid (valid_w[i+1]),
            .out_ctl   (ctl_w[i+1]),
            .out_res   (res_w[i+1]),
            .out_rem   (rem_w[i+1]),
            .out_dq    (dq_w[i+1]),
            .out_mb    (mb_w[i+1]),
            .out_prod  (prod_w[i+1]),
            .out_ash   (ash_w[i+1]),
            .out_bsh   (bsh_w[i+1])
        );
    end

    cfa_tail #(.DATA_WIDTH(DATA_WIDTH)) u_tail (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .in_valid       (valid_w[DATA_WIDTH]),
        .in_ctl         (ctl_w[DATA_WIDTH]),
        .in_res         (res_w[DATA_WIDTH]),
        .in_rem         (rem_w[DATA_WIDTH]),
        .in_dq          (dq_w[DATA_WIDTH]),
        .in_prod        (prod_w[DATA_WIDTH]),
        .pipe_en        (pipe_en),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_folded       (m_folded),
        .m_result_value (m_result_value),
        .m_divide_error (m_divide_error)
    );

`ifndef NO_ASSERTIONS
    a_fold_xor_error: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_folded && m_divide_error))
        else $error("A word reports both a fold and a divide error.");

    a_unfolded_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_folded) |-> (m_result_value == '0))
        else $error("A word that did not fold carries a nonzero value.");

    a_ready_drop: assert property (@(posedge aclk) disable iff (!aresetn)
        $fell(s_ready) |-> $past(m_valid && !m_ready))
        else $error("Input ready dropped without a stalled output word.");
`endif

endmodule

/* verif/constant_fold_alu_checker.sv */
`timescale 1ns / 1ps

module constant_fold_alu_checker import cfa_pkg::*; (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    input  logic                             s_ready,
    input  logic [OP_WIDTH-1:0]              s_op,
    input  logic signed [CFA_DATA_WIDTH-1:0] s_left_value,
    input  logic                             s_left_is_const,
    input  logic                             s_left_unsigned,
    input  logic signed [CFA_DATA_WIDTH-1:0] s_right_value,
    input  logic                             s_right_is_const,
    input  logic                             s_right_unsigned,
    input  logic signed [CFA_DATA_WIDTH-1:0] s_false_value,
    input  logic                             s_false_is_const,
    input  logic                             m_valid,
    input  logic                             m_ready,
    input  logic                             m_folded,
    input  logic signed [CFA_DATA_WIDTH-1:0] m_result_value,
    input  logic                             m_divide_error,
    output int                               fail_count,
    output int                               pending
);

    localparam int DW = CFA_DATA_WIDTH;

    typedef struct packed {
        logic          folded;
        logic [DW-1:0] value;
        logic          div_err;
    } fold_result_t;

    fold_result_t expected_folds[$];

    function automatic fold_result_t fold_expression(
        input logic [OP_WIDTH-1:0] op,
        input logic [DW-1:0]       a,
        input logic                ac,
        input logic                au,
        input logic [DW-1:0]       b,
        input logic                bc,
        input logic                bu,
        input logic [DW-1:0]       f,
        input logic                fc
    );
        fold_result_t  res;
        logic          uns;
        logic [DW-1:0] ma;
        logic [DW-1:0] mb;
        logic [DW-1:0] r;
        res = '0;
        uns = au || bu;
        r = '0;
        if (!ac) begin
            return res;
        end
        if (op == OP_SELECT) begin
            if (bc && fc) begin
                res.folded = 1'b1;
                res.value = (a != '0) ? b : f;
            end
            return res;
        end
        if (op == OP_NEG) begin
            res.folded = 1'b1;
            res.value = ~a + 1'b1;
            return res;
        end
        if (op == OP_COMPL) begin
            res.folded = 1'b1;
            res.value = ~a;
            return res;
        end
        if (op > OP_GE || !bc) begin
            return res;
        end
        res.folded = 1'b1;
        case (op)
            OP_ADD: r = a + b;
            OP_SUB: r = a - b;
            OP_MUL: r = a * b;
            OP_DIV, OP_MOD: begin
                if (b == '0) begin
                    res.folded = 1'b0;
                    res.div_err = 1'b1;
                end else if (uns) begin
                    r = (op == OP_DIV) ? a / b : a % b;
                end else begin
                    ma = a[DW-1] ? ~a + 1'b1 : a;
                    mb = b[DW-1] ? ~b + 1'b1 : b;
                    if (op == OP_DIV) begin
                        r = ma / mb;
                        if (a[DW-1] != b[DW-1]) begin
                            r = ~r + 1'b1;
                        end
                    end else begin
                        r = ma % mb;
                        if (a[DW-1]) begin
                            r = ~r + 1'b1;
                        end
                    end
                end
            end
            OP_AND: r = a & b;
            OP_OR:  r = a | b;
            OP_XOR: r = a ^ b;
            OP_SHL: r = (b >= DW) ? '0 : a << b;
            OP_SHR: begin
                if (b >= DW) begin
                    r = (!uns && a[DW-1]) ? '1 : '0;
                end else if (uns) begin
                    r = a >> b;
                end else begin
                    r = $signed(a) >>> b;
                end
            end
            OP_EQ: r = DW'(a == b);
            OP_NE: r = DW'(a != b);
            OP_LT: r = DW'($signed(a) < $signed(b));
            OP_GT: r = DW'($signed(a) > $signed(b));
            OP_LE: r = DW'($signed(a) <= $signed(b));
            default: r = DW'($signed(a) >= $signed(b));
        endcase
        res.value = res.folded ? r : '0;
        return res;
    endfunction

    initial begin
        fail_count = 0;
        pending = 0;
    end

    always @(posedge aclk) begin
        fold_result_t want;
        int           errors;
        errors = 0;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (expected_folds.size() == 0) begin
                    $display("%0t: unexpected result word folded=%0b value=%h div_err=%0b",
                             $time, m_folded, m_result_value, m_divide_error);
                    errors++;
                end else begin
                    want = expected_folds.pop_front();
                    if (m_folded !== want.folded) begin
                        $display("%0t: folded expected %0b actual %0b",
                                 $time, want.folded, m_folded);
                        errors++;
                    end
                    if (m_result_value !== want.value) begin
                        $display("%0t: result_value expected %h actual %h",
                                 $time, want.value, m_result_value);
                        errors++;
                    end
                    if (m_divide_error !== want.div_err) begin
                        $display("%0t: divide_error expected %0b actual %0b",
                                 $time, want.div_err, m_divide_error);
                        errors++;
                    end
                end
            end
            if (s_valid && s_ready) begin
                expected_folds.push_back(fold_expression(
                    s_op, s_left_value, s_left_is_const, s_left_unsigned,
                    s_right_value, s_right_is_const, s_right_unsigned,
                    s_false_value, s_false_is_const));
            end
        end
        fail_count <= fail_count + errors;
        pending <= expected_folds.size();
    end

endmodule

/* verif/constant_fold_alu_test.sv */
`timescale 1ns / 1ps

module constant_fold_alu_test;
    import cfa_pkg::*;

    localparam int DW = CFA_DATA_WIDTH;
    localparam logic [OP_WIDTH-1:0] OP_OTHER = 5'd19;
    localparam int RANDOM_WORDS = 400;
    localparam int SETTLE_CYCLES = 2 * (DW + 2);
    localparam int IDLE_LIMIT = 2000;

    logic                 aclk = 1'b0;
    logic                 aresetn;
    logic                 s_valid;
    logic                 s_ready;
    logic [OP_WIDTH-1:0]  s_op;
    logic signed [DW-1:0] s_left_value;
    logic                 s_left_is_const;
    logic                 s_left_unsigned;
    logic signed [DW-1:0] s_right_value;
    logic                 s_right_is_const;
    logic                 s_right_unsigned;
    logic signed [DW-1:0] s_false_value;
    logic                 s_false_is_const;
    logic                 m_valid;
    logic                 m_ready;
    logic                 m_folded;
    logic signed [DW-1:0] m_result_value;
    logic                 m_divide_error;

    int fail_count;
    int pending;
    int burst_left = 0;
    int idle_cycles = 0;
    int stall_left = 0;
    int stall_mode = 0;

    constant_fold_alu u_dut (.*);

    constant_fold_alu_checker u_checker (.*);

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        if (stall_left == 0) begin
            stall_mode <= $urandom_range(0, 3);
            stall_left <= $urandom_range(8, 40);
        end else begin
            stall_left <= stall_left - 1;
        end
        case (stall_mode)
            0: m_ready <= 1'b1;
            1: m_ready <= 1'($urandom_range(0, 1));
            2: m_ready <= (stall_left % 3 == 0);
            default: m_ready <= 1'b0;
        endcase
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic send_word(
        input logic [OP_WIDTH-1:0] op,
        input logic [DW-1:0]       a,
        input logic                ac,
        input logic                au,
        input logic [DW-1:0]       b,
        input logic                bc,
        input logic                bu,
        input logic [DW-1:0]       f,
        input logic                fc
    );
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_valid <= 1'b1;
        s_op <= op;
        s_left_value <= a;
        s_left_is_const <= ac;
        s_left_unsigned <= au;
        s_right_value <= b;
        s_right_is_const <= bc;
        s_right_unsigned <= bu;
        s_false_value <= f;
        s_false_is_const <= fc;
        do @(posedge aclk); while (!s_ready);
    endtask

    // The pending count is registered and lags behind an acceptance, hence the wait before it is polled.
    task automatic drain_results();
        s_valid <= 1'b0;
        burst_left = 0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
    endtask

    function automatic logic [DW-1:0] pick_operand();
        case ($urandom_range(0, 7))
            0: return 16'h0000;
            1: return 16'h0001;
            2: return 16'hFFFF;
            3: return 16'h7FFF;
            4: return 16'h8000;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic send_random_word();
        logic [OP_WIDTH-1:0] op;
        logic [DW-1:0]       a;
        logic [DW-1:0]       b;
        logic [DW-1:0]       f;
        if ($urandom_range(0, 9) == 0) begin
            op = OP_WIDTH'($urandom_range(OP_OTHER, 31));
        end else begin
            op = OP_WIDTH'($urandom_range(OP_ADD, OP_SELECT));
        end
        a = pick_operand();
        b = pick_operand();
        f = pick_operand();
        if (op == OP_SHL || op == OP_SHR) begin
            if ($urandom_range(0, 4) != 0) begin
                b = DW'($urandom_range(0, 17));
            end
        end else if (op == OP_DIV || op == OP_MOD) begin
            case ($urandom_range(0, 7))
                0: b = '0;
                1, 2: b = DW'($urandom_range(1, 9));
                3: b = '1;
                default: ;
            endcase
        end else if (op == OP_SELECT && $urandom_range(0, 2) == 0) begin
            a = '0;
        end
        send_word(op, a, $urandom_range(0, 9) != 0, $urandom_range(0, 3) == 0,
                  b, $urandom_range(0, 9) != 0, $urandom_range(0, 3) == 0,
                  f, $urandom_range(0, 9) != 0);
    endtask

    initial begin
        aresetn <= 1'b0;
        s_valid <= 1'b0;
        s_op <= OP_ADD;
        s_left_value <= '0;
        s_left_is_const <= 1'b0;
        s_left_unsigned <= 1'b0;
        s_right_value <= '0;
        s_right_is_const <= 1'b0;
        s_right_unsigned <= 1'b0;
        s_false_value <= '0;
        s_false_is_const <= 1'b0;
        m_ready <= 1'b0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        send_word(OP_ADD,    16'h7FFF, 1, 0, 16'h0001, 1, 0, 16'h0000, 0);
        send_word(OP_SUB,    16'h8000, 1, 0, 16'h0001, 1, 0, 16'h0000, 0);
        send_word(OP_MUL,    16'h7FFF, 1, 1, 16'h7FFF, 1, 0, 16'h0000, 0);
        send_word(OP_DIV,    16'h8000, 1, 0, 16'hFFFF, 1, 0, 16'h0000, 0);
        send_word(OP_MOD,    16'h8000, 1, 0, 16'hFFFF, 1, 0, 16'h0000, 0);
        send_word(OP_DIV,    16'hFFF9, 1, 0, 16'h0002, 1, 0, 16'h0000, 0);
        send_word(OP_MOD,    16'hFFF9, 1, 1, 16'h0002, 1, 0, 16'h0000, 0);
        send_word(OP_DIV,    16'h0005, 1, 0, 16'h0000, 1, 0, 16'h0000, 0);
        send_word(OP_MOD,    16'h0005, 1, 0, 16'h0000, 1, 1, 16'h0000, 0);
        send_word(OP_AND,    16'hF0F0, 1, 0, 16'hFF00, 1, 0, 16'h0000, 0);
        send_word(OP_OR,     16'hF0F0, 1, 0, 16'h0F0F, 1, 0, 16'h0000, 0);
        send_word(OP_XOR,    16'hFFFF, 1, 0, 16'hAAAA, 1, 0, 16'h0000, 0);
        send_word(OP_NEG,    16'h8000, 1, 0, 16'h1234, 0, 0, 16'h0000, 0);
        send_word(OP_COMPL,  16'h0000, 1, 0, 16'h0000, 0, 0, 16'h0000, 0);
        send_word(OP_SHL,    16'h0001, 1, 0, 16'h000F, 1, 0, 16'h0000, 0);
        send_word(OP_SHL,    16'h0001, 1, 0, 16'hFFFF, 1, 0, 16'h0000, 0);
        send_word(OP_SHR,    16'h8000, 1, 0, 16'h0014, 1, 0, 16'h0000, 0);
        send_word(OP_SHR,    16'h8000, 1, 0, 16'h0003, 1, 1, 16'h0000, 0);
        send_word(OP_EQ,     16'hFFFF, 1, 0, 16'hFFFF, 1, 0, 16'h0000, 0);
        send_word(OP_NE,     16'hFFFF, 1, 0, 16'h7FFF, 1, 0, 16'h0000, 0);
        send_word(OP_LT,     16'hFFFF, 1, 1, 16'h0001, 1, 1, 16'h0000, 0);
        send_word(OP_GT,     16'h8000, 1, 0, 16'h7FFF, 1, 0, 16'h0000, 0);
        send_word(OP_LE,     16'h0005, 1, 0, 16'h0005, 1, 0, 16'h0000, 0);
        send_word(OP_GE,     16'h8000, 1, 0, 16'h8000, 1, 0, 16'h0000, 0);
        send_word(OP_SELECT, 16'h0000, 1, 0, 16'h1111, 1, 0, 16'h2222, 1);
        send_word(OP_SELECT, 16'h0001, 1, 0, 16'h1111, 1, 0, 16'h2222, 0);
        send_word(OP_OTHER,  16'h0003, 1, 0, 16'h0004, 1, 0, 16'h0005, 1);
        send_word(OP_DIV,    16'h0005, 0, 0, 16'h0000, 1, 0, 16'h0000, 0);
        drain_results();

        for (int n = 0; n < RANDOM_WORDS; n++) begin
            if (n == RANDOM_WORDS / 2) begin
                drain_results();
            end
            send_random_word();
        end
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge aclk);

        if (fail_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

/* constant_fold_alu.f */
src/cfa_pkg.sv
src/cfa_front.sv
src/cfa_cell.sv
src/cfa_tail.sv
src/constant_fold_alu.sv
verif/constant_fold_alu_checker.sv
verif/constant_fold_alu_test.sv
